FILE: design/dmdsl_pkg.sv
`default_nettype none

package dmdsl_pkg;

   // operation codes of an input item
   typedef enum logic [1:0] {
      OP_WRITE_NOW    = 2'd0,
      OP_WRITE_TARGET = 2'd1,
      OP_TICK         = 2'd2,
      OP_READ         = 2'd3
   } op_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_RAMP_STEP      = 2'd0,
      CSR_DUTY_LIMIT_POS = 2'd1,
      CSR_DUTY_LIMIT_NEG = 2'd2,
      CSR_PWM_TOP        = 2'd3
   } csr_index_type;

   localparam int unsigned FIELD_WIDTH = 16;
   localparam int unsigned STEP_WIDTH  = 15;

   // reset values: ramp step is max/8
   localparam logic [STEP_WIDTH-1:0]         RAMP_STEP_RESET      = 15'd125;
   localparam logic [STEP_WIDTH-1:0]         DUTY_LIMIT_POS_RESET = 15'd1000;
   localparam logic signed [FIELD_WIDTH-1:0] DUTY_LIMIT_NEG_RESET = -16'sd1000;
   localparam logic [FIELD_WIDTH-1:0]        PWM_TOP_RESET        = 16'd1000;

endpackage

`default_nettype wire

FILE: design/dual_motor_duty_slew_limiter.sv
`default_nettype none

// Dual H-bridge duty controller with slew limiting. Each motor holds a present
// (applied) duty and a target duty. An input transfer carries one operation:
// write now sets target and applies the duty at once, write target sets only
// the target, tick moves every motor one ramp step toward its target without
// overshoot, read changes nothing. Applied duties clamp to duty_limit_pos and
// duty_limit_neg, stored targets saturate to the DUTY_WIDTH signed range. Each
// input transfer yields exactly one result transfer with both motor drives
// (negative duty sets reverse and drives pwm_top plus duty, floored at 0) and
// the read-back of the addressed motor; ids at or above NUM_MOTORS are ignored
// and read as 0. The block takes one item per cycle unless the result side
// stalls; an item passes the input register, then the update logic feeding the
// result register. The user must write the registers through the csr port only
// while the block is idle; the block itself does not enforce this.

module dual_motor_duty_slew_limiter #(
   parameter int unsigned NUM_MOTORS = 2,
   parameter int unsigned DUTY_WIDTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [1:0]  req_motor_id,
   input  wire logic signed [15:0] req_duty_value,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_left_pwm,
   output logic             rsp_left_reverse,
   output logic [15:0]      rsp_right_pwm,
   output logic             rsp_right_reverse,
   output logic signed [15:0] rsp_read_present,
   output logic signed [15:0] rsp_read_target,

   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wr_data
);

   // working width: holds any duty, any 16 bit field and a sum of two
   localparam int unsigned WW = ((DUTY_WIDTH > 16) ? DUTY_WIDTH : 16) + 2;
   localparam logic signed [WW-1:0] DUTY_HI = WW'({1'b0, {(DUTY_WIDTH-1){1'b1}}});
   localparam logic signed [WW-1:0] DUTY_LO = ~DUTY_HI;

   // ---------------------------------------------------------------- helpers
   function automatic logic signed [WW-1:0] sat_width(input logic signed [WW-1:0] v);
      logic signed [WW-1:0] r;
      r = v;
      if (v > DUTY_HI) begin
         r = DUTY_HI;
      end else if (v < DUTY_LO) begin
         r = DUTY_LO;
      end
      return r;
   endfunction

   // clamp to the configured limits, then to the stored range
   function automatic logic signed [WW-1:0] apply_limits(
      input logic signed [WW-1:0] v,
      input logic [14:0]          lim_pos,
      input logic signed [15:0]   lim_neg
   );
      logic signed [WW-1:0] pos;
      logic signed [WW-1:0] neg;
      logic signed [WW-1:0] r;
      pos = signed'({{(WW-15){1'b0}}, lim_pos});
      neg = {{(WW-16){lim_neg[15]}}, lim_neg};
      r   = v;
      if (v >= 0) begin
         if (v > pos) begin
            r = pos;
         end
      end else begin
         if (v < neg) begin
            r = neg;
         end
      end
      return sat_width(r);
   endfunction

   // one ramp step toward the target, never past it
   function automatic logic signed [WW-1:0] ramp_toward(
      input logic signed [WW-1:0] now,
      input logic signed [WW-1:0] tgt,
      input logic [14:0]          step
   );
      logic signed [WW-1:0] diff;
      logic signed [WW-1:0] st;
      diff = (tgt > now) ? (tgt - now) : (now - tgt);
      st   = signed'({{(WW-15){1'b0}}, step});
      if (st > diff) begin
         st = diff;
      end
      return (tgt > now) ? (now + st) : (now - st);
   endfunction

   function automatic logic signed [WW-1:0] sext_duty(
      input logic signed [DUTY_WIDTH-1:0] d
   );
      return {{(WW-DUTY_WIDTH){d[DUTY_WIDTH-1]}}, d};
   endfunction

   function automatic logic [15:0] drive_pwm(
      input logic signed [DUTY_WIDTH-1:0] d,
      input logic [15:0]                  top
   );
      logic signed [WW-1:0] w;
      logic signed [WW-1:0] p;
      w = sext_duty(d);
      p = signed'({{(WW-16){1'b0}}, top}) + w;
      if (w >= 0) begin
         return w[15:0];
      end else if (p < 0) begin
         return 16'd0;
      end else begin
         return p[15:0];
      end
   endfunction

   // ---------------------------------------------------------- configuration
   logic [14:0]        ramp_step_ff;
   logic [14:0]        lim_pos_ff;
   logic signed [15:0] lim_neg_ff;
   logic [15:0]        pwm_top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_step_ff <= dmdsl_pkg::RAMP_STEP_RESET;
         lim_pos_ff   <= dmdsl_pkg::DUTY_LIMIT_POS_RESET;
         lim_neg_ff   <= dmdsl_pkg::DUTY_LIMIT_NEG_RESET;
         pwm_top_ff   <= dmdsl_pkg::PWM_TOP_RESET;
      end else if (csr_wr_en) begin
         case (dmdsl_pkg::csr_index_type'(csr_index))
            dmdsl_pkg::CSR_RAMP_STEP:      ramp_step_ff <= csr_wr_data[14:0];
            dmdsl_pkg::CSR_DUTY_LIMIT_POS: lim_pos_ff   <= csr_wr_data[14:0];
            dmdsl_pkg::CSR_DUTY_LIMIT_NEG: lim_neg_ff   <= signed'(csr_wr_data);
            dmdsl_pkg::CSR_PWM_TOP:        pwm_top_ff   <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------- pipeline ctrl
   logic                 in_valid_ff;
   dmdsl_pkg::op_type    in_op_ff;
   logic [1:0]           in_id_ff;
   logic signed [15:0]   in_duty_ff;
   logic                 rsp_valid_ff;
   logic                 advance;

   // result register free or being emptied this cycle
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_op_ff   <= dmdsl_pkg::op_type'(req_opcode);
         in_id_ff   <= req_motor_id;
         in_duty_ff <= req_duty_value;
      end
   end

   // ------------------------------------------------------------ duty state
   logic signed [DUTY_WIDTH-1:0] present_ff [NUM_MOTORS];
   logic signed [DUTY_WIDTH-1:0] target_ff  [NUM_MOTORS];
   logic signed [DUTY_WIDTH-1:0] present_in [NUM_MOTORS];
   logic signed [DUTY_WIDTH-1:0] target_in  [NUM_MOTORS];
   logic                         id_hit     [NUM_MOTORS];
   logic signed [WW-1:0]         duty_w;

   assign duty_w = {{(WW-16){in_duty_ff[15]}}, in_duty_ff};

   always_comb begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
         id_hit[i]     = (int'(in_id_ff) == i);
         present_in[i] = present_ff[i];
         target_in[i]  = target_ff[i];
         case (in_op_ff)
            dmdsl_pkg::OP_WRITE_NOW: begin
               if (id_hit[i]) begin
                  target_in[i]  = DUTY_WIDTH'(sat_width(duty_w));
                  present_in[i] = DUTY_WIDTH'(apply_limits(duty_w, lim_pos_ff,
                                                           lim_neg_ff));
               end
            end
            dmdsl_pkg::OP_WRITE_TARGET: begin
               if (id_hit[i]) begin
                  target_in[i] = DUTY_WIDTH'(sat_width(duty_w));
               end
            end
            dmdsl_pkg::OP_TICK: begin
               // motors already at target are left alone
               if (present_ff[i] != target_ff[i]) begin
                  present_in[i] = DUTY_WIDTH'(apply_limits(
                     ramp_toward(sext_duty(present_ff[i]), sext_duty(target_ff[i]),
                                 ramp_step_ff),
                     lim_pos_ff, lim_neg_ff));
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_MOTORS; i++) begin
            present_ff[i] <= '0;
            target_ff[i]  <= '0;
         end
      end else if (advance && in_valid_ff) begin
         for (int i = 0; i < NUM_MOTORS; i++) begin
            present_ff[i] <= present_in[i];
            target_ff[i]  <= target_in[i];
         end
      end
   end

   // ---------------------------------------------------------------- result
   logic [15:0]        drive_pwm_w [NUM_MOTORS];
   logic               drive_rev_w [NUM_MOTORS];
   logic [15:0]        right_pwm_w;
   logic               right_rev_w;
   logic signed [15:0] read_present_w;
   logic signed [15:0] read_target_w;
   logic signed [WW-1:0] pres_sel;
   logic signed [WW-1:0] tgt_sel;

   always_comb begin
      pres_sel = '0;
      tgt_sel  = '0;
      for (int i = 0; i < NUM_MOTORS; i++) begin
         drive_pwm_w[i] = drive_pwm(present_in[i], pwm_top_ff);
         drive_rev_w[i] = present_in[i][DUTY_WIDTH-1];
         // addressed motor read-back, zero for ids beyond the motor count
         if (id_hit[i]) begin
            pres_sel = sext_duty(present_in[i]);
            tgt_sel  = sext_duty(target_in[i]);
         end
      end
      read_present_w = pres_sel[15:0];
      read_target_w  = tgt_sel[15:0];
   end

   // a single-motor build drives the right bridge off
   if (NUM_MOTORS > 1) begin : g_right
      assign right_pwm_w = drive_pwm_w[1];
      assign right_rev_w = drive_rev_w[1];
   end else begin : g_no_right
      assign right_pwm_w = 16'd0;
      assign right_rev_w = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   logic [15:0]        left_pwm_ff;
   logic               left_rev_ff;
   logic [15:0]        right_pwm_ff;
   logic               right_rev_ff;
   logic signed [15:0] read_present_ff;
   logic signed [15:0] read_target_ff;

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         left_pwm_ff     <= drive_pwm_w[0];
         left_rev_ff     <= drive_rev_w[0];
         right_pwm_ff    <= right_pwm_w;
         right_rev_ff    <= right_rev_w;
         read_present_ff <= read_present_w;
         read_target_ff  <= read_target_w;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_pwm      = left_pwm_ff;
   assign rsp_left_reverse  = left_rev_ff;
   assign rsp_right_pwm     = right_pwm_ff;
   assign rsp_right_reverse = right_rev_ff;
   assign rsp_read_present  = read_present_ff;
   assign rsp_read_target   = read_target_ff;

endmodule

`default_nettype wire

FILE: dv/tb_dual_motor_duty_slew_limiter.sv
module tb_dual_motor_duty_slew_limiter;
   timeunit 1ns;
   timeprecision 1ps;

   // two motors and 16 bit duties, as the block is built by default
   localparam int MOTORS      = 2;
   // a run this long with no transfer on either side means the block is stuck
   localparam int QUIET_LIMIT = 5000;

   // one result transfer: both bridge drives plus the read-back
   typedef struct {
      logic [15:0]        left_pwm;
      logic               left_reverse;
      logic [15:0]        right_pwm;
      logic               right_reverse;
      logic signed [15:0] read_present;
      logic signed [15:0] read_target;
   } drive_report_type;

   logic                     clock;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_opcode     = dmdsl_pkg::OP_READ;
   logic [1:0]               req_motor_id   = 2'd0;
   logic signed [15:0]       req_duty_value = 16'sd0;
   logic                     rsp_valid;
   logic                     rsp_stall      = 1'b0;
   logic [15:0]              rsp_left_pwm;
   logic                     rsp_left_reverse;
   logic [15:0]              rsp_right_pwm;
   logic                     rsp_right_reverse;
   logic signed [15:0]       rsp_read_present;
   logic signed [15:0]       rsp_read_target;
   logic                     csr_wr_en      = 1'b0;
   dmdsl_pkg::csr_index_type csr_index      = dmdsl_pkg::CSR_RAMP_STEP;
   logic [15:0]              csr_wr_data    = 16'd0;

   // idle rates in percent of cycles, changed per phase
   int req_idle_pct  = 24;
   int rsp_stall_pct = 56;
   int mismatch_count = 0;
   int quiet_cycles   = 0;

   // motor state and register copies used for prediction
   logic signed [15:0] now_duty [MOTORS] = '{default: 16'sd0};
   logic signed [15:0] aim_duty [MOTORS] = '{default: 16'sd0};
   logic [14:0]        cfg_ramp    = dmdsl_pkg::RAMP_STEP_RESET;
   logic [14:0]        cfg_lim_pos = dmdsl_pkg::DUTY_LIMIT_POS_RESET;
   logic signed [15:0] cfg_lim_neg = dmdsl_pkg::DUTY_LIMIT_NEG_RESET;
   logic [15:0]        cfg_pwm_top = dmdsl_pkg::PWM_TOP_RESET;

   // drives still owed by the block, oldest first
   drive_report_type pending_drives [$];

   dual_motor_duty_slew_limiter dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_motor_id      (req_motor_id),
      .req_duty_value    (req_duty_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_left_pwm      (rsp_left_pwm),
      .rsp_left_reverse  (rsp_left_reverse),
      .rsp_right_pwm     (rsp_right_pwm),
      .rsp_right_reverse (rsp_right_reverse),
      .rsp_read_present  (rsp_read_present),
      .rsp_read_target   (rsp_read_target),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // clamp a duty to the configured limits, then to the 16 bit signed range
   function automatic logic signed [15:0] applied_duty(int d);
      int r;
      r = d;
      if (d >= 0) begin
         if (d > int'(cfg_lim_pos)) r = int'(cfg_lim_pos);
      end else if (d < int'(cfg_lim_neg)) begin
         r = int'(cfg_lim_neg);
      end
      if (r > 32767) r = 32767;
      else if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   // {reverse, pwm}: reverse drive inverts against pwm_top, floored at 0
   function automatic logic [16:0] bridge_drive(logic signed [15:0] d);
      int p;
      if (d >= 0) return {1'b0, d};
      p = int'(cfg_pwm_top) + int'(d);
      if (p < 0) p = 0;
      return {1'b1, p[15:0]};
   endfunction

   // apply one operation to the motor state and build the drive it reports
   function automatic drive_report_type step_motors(dmdsl_pkg::op_type op, logic [1:0] id,
                                                    logic signed [15:0] duty);
      drive_report_type r;
      logic [16:0]      bridge;
      int               cur, aim, gap, st;
      bit               known;
      known = (int'(id) < MOTORS);
      case (op)
         dmdsl_pkg::OP_WRITE_NOW: begin
            if (known) begin
               aim_duty[id] = duty;
               now_duty[id] = applied_duty(duty);
            end
         end
         dmdsl_pkg::OP_WRITE_TARGET: begin
            if (known) aim_duty[id] = duty;
         end
         dmdsl_pkg::OP_TICK: begin
            // id and duty are don't-care; every motor off target slews one step
            for (int m = 0; m < MOTORS; m++) begin
               cur = now_duty[m];
               aim = aim_duty[m];
               if (cur != aim) begin
                  gap = (aim > cur) ? aim - cur : cur - aim;
                  st  = int'(cfg_ramp);
                  if (st > gap) st = gap;   // no overshoot past the target
                  now_duty[m] = applied_duty((aim > cur) ? cur + st : cur - st);
               end
            end
         end
         default: ;
      endcase
      bridge          = bridge_drive(now_duty[0]);
      r.left_pwm      = bridge[15:0];
      r.left_reverse  = bridge[16];
      bridge          = bridge_drive(now_duty[1]);
      r.right_pwm     = bridge[15:0];
      r.right_reverse = bridge[16];
      r.read_present  = known ? now_duty[id] : 16'sd0;
      r.read_target   = known ? aim_duty[id] : 16'sd0;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%04h want 0x%04h", name, got, want));
   endtask

   // outputs sampled at the rising edge, before the block's own updates land
   always @(posedge clock) begin
      drive_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_drives.size() == 0) begin
            report_mismatch("result transfer with no item outstanding");
         end else begin
            want = pending_drives.pop_front();
            check_field("left_pwm",      rsp_left_pwm,      want.left_pwm);
            check_field("left_reverse",  16'(rsp_left_reverse),
                        16'(want.left_reverse));
            check_field("right_pwm",     rsp_right_pwm,     want.right_pwm);
            check_field("right_reverse", 16'(rsp_right_reverse),
                        16'(want.right_reverse));
            check_field("read_present",  rsp_read_present,  want.read_present);
            check_field("read_target",   rsp_read_target,   want.read_target);
         end
      end
   end

   // receiver back-pressure, one decision per falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // watchdog: cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("dual_motor_duty_slew_limiter test failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // present one item, hold it through stalls, predict once it transfers;
   // valid is touched once per falling edge so back-to-back items stay high
   task automatic send_item(dmdsl_pkg::op_type op, logic [1:0] id,
                            logic signed [15:0] duty);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_motor_id   <= id;
      req_duty_value <= duty;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_drives.push_back(step_motors(op, id, duty));
   endtask

   // drop valid and hold off until every drive has come back,
   // then let the two-stage pipeline settle before returning
   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_drives.size() != 0) @(posedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_csr(dmdsl_pkg::csr_index_type idx, logic [15:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      case (idx)
         dmdsl_pkg::CSR_RAMP_STEP:      cfg_ramp    = data[14:0];
         dmdsl_pkg::CSR_DUTY_LIMIT_POS: cfg_lim_pos = data[14:0];
         dmdsl_pkg::CSR_DUTY_LIMIT_NEG: cfg_lim_neg = data;
         dmdsl_pkg::CSR_PWM_TOP:        cfg_pwm_top = data;
         default: ;
      endcase
   endtask

   // registers only change with the block empty
   task automatic load_config(logic [15:0] ramp, logic [15:0] lim_pos,
                              logic [15:0] lim_neg, logic [15:0] pwm_top);
      quiesce();
      write_csr(dmdsl_pkg::CSR_RAMP_STEP, ramp);
      write_csr(dmdsl_pkg::CSR_DUTY_LIMIT_POS, lim_pos);
      write_csr(dmdsl_pkg::CSR_DUTY_LIMIT_NEG, lim_neg);
      write_csr(dmdsl_pkg::CSR_PWM_TOP, pwm_top);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // random settings: mostly modest limits so ramps take several ticks,
   // now and then the ramp step extremes or a zero duty limit
   task automatic shuffle_config();
      int ramp, pos, neg, top;
      case ($urandom_range(5))
         0:       ramp = 1;
         1:       ramp = 32767;
         2:       ramp = $urandom_range(1, 32767);
         default: ramp = $urandom_range(1, 400);
      endcase
      case ($urandom_range(5))
         0:       pos = 0;
         1:       pos = $urandom_range(0, 32767);
         default: pos = $urandom_range(0, 2500);
      endcase
      case ($urandom_range(5))
         0:       neg = 0;
         1:       neg = -int'($urandom_range(0, 32768));
         default: neg = -int'($urandom_range(0, 2500));
      endcase
      top = ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3000);
      load_config(ramp[15:0], pos[15:0], neg[15:0], top[15:0]);
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // reset limits: clamping both ways, slewing, out-of-range targets, bad ids
   task automatic test_reset_state();
      req_idle_pct  = 24;
      rsp_stall_pct = 56;
      send_item(dmdsl_pkg::OP_READ, 2'd0, 16'sd0);
      send_item(dmdsl_pkg::OP_READ, 2'd1, 16'sd0);
      send_item(dmdsl_pkg::OP_WRITE_NOW, 2'd0, 16'sh7fff);     // clamps to the positive limit
      send_item(dmdsl_pkg::OP_WRITE_NOW, 2'd1, 16'sh8000);     // clamps to the negative limit
      send_item(dmdsl_pkg::OP_WRITE_TARGET, 2'd0, -16'sd300);
      send_item(dmdsl_pkg::OP_TICK, 2'd0, 16'sd0);
      send_item(dmdsl_pkg::OP_TICK, 2'd1, 16'sd0);
      send_item(dmdsl_pkg::OP_WRITE_TARGET, 2'd1, -16'sd5000); // target past the limit
      send_item(dmdsl_pkg::OP_TICK, 2'd0, 16'sd0);             // present stays pinned
      send_item(dmdsl_pkg::OP_WRITE_NOW, 2'd2, 16'sd500);      // ignored ids
      send_item(dmdsl_pkg::OP_WRITE_TARGET, 2'd3, -16'sd1);
      send_item(dmdsl_pkg::OP_READ, 2'd2, 16'sd0);
      send_item(dmdsl_pkg::OP_READ, 2'd3, 16'sd0);
      send_item(dmdsl_pkg::OP_TICK, 2'd3, 16'sh8000);          // tick ignores id and duty
      send_item(dmdsl_pkg::OP_WRITE_NOW, 2'd0, 16'sd0);
      send_item(dmdsl_pkg::OP_WRITE_NOW, 2'd1, -16'sd1);       // reverse, pwm just under top
   endtask

   // every register at its top, then at its floor, including a zero ramp step
   task automatic test_register_extremes();
      load_config(16'h7fff, 16'h7fff, 16'h8000, 16'hffff);
      send_item(dmdsl_pkg::OP_WRITE_NOW, 2'd0, 16'sh7fff);
      send_item(dmdsl_pkg::OP_WRITE_NOW, 2'd1, 16'sh8000);
      send_item(dmdsl_pkg::OP_WRITE_TARGET, 2'd0, 16'sh8000);
      send_item(dmdsl_pkg::OP_TICK, 2'd0, 16'sd0);             // step smaller than the gap
      send_item(dmdsl_pkg::OP_TICK, 2'd1, 16'sd0);             // second step still short of the target
      load_config(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_item(dmdsl_pkg::OP_WRITE_TARGET, 2'd1, 16'sd100);
      send_item(dmdsl_pkg::OP_TICK, 2'd0, 16'sd0);             // zero step only re-applies limits
      send_item(dmdsl_pkg::OP_WRITE_NOW, 2'd0, 16'sd5000);
      load_config(16'd125, 16'd1000, 16'h8000, 16'h0000);
      send_item(dmdsl_pkg::OP_WRITE_NOW, 2'd1, -16'sd7);       // pwm floored at zero
   endtask

   // random traffic with mid-phase register changes; ticks and target writes
   // dominate so ramps actually run toward and against the limits
   task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
      int                 pick, v;
      dmdsl_pkg::op_type  op;
      logic [1:0]         id;
      logic signed [15:0] duty;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         if (i % 120 == 0) shuffle_config();
         pick = $urandom_range(99);
         if (pick < 35)      op = dmdsl_pkg::OP_TICK;
         else if (pick < 62) op = dmdsl_pkg::OP_WRITE_TARGET;
         else if (pick < 82) op = dmdsl_pkg::OP_WRITE_NOW;
         else                op = dmdsl_pkg::OP_READ;
         id = ($urandom_range(9) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
         case ($urandom_range(9))
            0: duty = 16'($urandom);
            1: duty = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: begin
               v    = int'($urandom_range(0, 6000)) - 3000;
               duty = v[15:0];
            end
         endcase
         send_item(op, id, duty);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_register_extremes();
      test_random_traffic(540, 24, 56);
      test_random_traffic(540, 56, 24);
      test_random_traffic(520, 0, 0);
      quiesce();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("dual_motor_duty_slew_limiter test passed");
      end else begin
         $display("dual_motor_duty_slew_limiter test failed");
      end
      $finish;
   end

endmodule
